// ===== rtl/core/fbfl_pkg.sv =====
// shared types, codes and constants of the fixed block free list allocator
package fbfl_pkg;

	localparam int DEF_MAX_BLOCKS = 256;

	localparam int ACT_W    = 2;
	localparam int CNT_W    = 9;
	localparam int SIZE_W   = 16;
	localparam int GIDX_W   = 8;
	localparam int OFF_W    = 24;
	localparam int STAT_W   = 2;
	localparam int TOTAL_W  = 64;
	localparam int FAIL_W   = 32;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 208;

	localparam logic [ACT_W-1:0] ACT_INIT  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK            = 2'd0;
	localparam logic [STAT_W-1:0] ST_OUT_OF_BLOCKS = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_INIT      = 2'd2;
	localparam logic [STAT_W-1:0] ST_IGNORED       = 2'd3;

	localparam logic REG_BLOCK_COUNT = 1'b0;
	localparam logic REG_BLOCK_SIZE  = 1'b1;

	localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 9'd256;
	localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 16'd64;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_INIT,
		FSM_RESP
	} fsm_state_t;

	typedef struct packed {
		logic accept;
		logic walk;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic init_go;
		logic walk_last;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/core/fbfl_ctrl.sv =====
// controller state machine of the free list allocator
module fbfl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  fbfl_pkg::dp_stat_t  stat,
	output fbfl_pkg::ctrl_cmd_t cmd
);

	fbfl_pkg::fsm_state_t state_q;
	fbfl_pkg::fsm_state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbfl_pkg::FSM_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			fbfl_pkg::FSM_IDLE: begin
				if (s_tvalid) begin
					state_n = stat.init_go ? fbfl_pkg::FSM_INIT : fbfl_pkg::FSM_RESP;
				end
			end
			fbfl_pkg::FSM_INIT: begin
				if (stat.walk_last) begin
					state_n = fbfl_pkg::FSM_RESP;
				end
			end
			fbfl_pkg::FSM_RESP: begin
				if (stat.out_free) begin
					state_n = fbfl_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_n = fbfl_pkg::FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.walk   = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			fbfl_pkg::FSM_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			fbfl_pkg::FSM_INIT: begin
				cmd.walk = 1'b1;
			end
			fbfl_pkg::FSM_RESP: begin
				cmd.finish = stat.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/core/fbfl_dpath.sv =====
// datapath of the free list allocator: link table, list head, counters, result register
module fbfl_dpath #(
	parameter int MAX_BLOCKS = fbfl_pkg::DEF_MAX_BLOCKS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [fbfl_pkg::SIZE_W-1:0]          cfg_wdata,
	input  logic [fbfl_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  logic                                 m_tready,
	output logic                                 m_tvalid,
	output logic [fbfl_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  fbfl_pkg::ctrl_cmd_t                  cmd,
	output fbfl_pkg::dp_stat_t                   stat
);

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
	localparam int PW     = IDX_W + fbfl_pkg::SIZE_W;
	localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_BLOCKS);

	// configuration registers
	logic [fbfl_pkg::CNT_W-1:0]  block_count_q;
	logic [fbfl_pkg::SIZE_W-1:0] block_size_q;

	// pool state
	logic [LINK_W-1:0]            head_q;
	logic                         pool_ready_q;
	logic [fbfl_pkg::CNT_W-1:0]   pool_count_q;
	logic [fbfl_pkg::SIZE_W-1:0]  pool_size_q;
	logic [fbfl_pkg::CNT_W-1:0]   fc_q;
	logic [fbfl_pkg::TOTAL_W-1:0] alloc_q;
	logic [fbfl_pkg::TOTAL_W-1:0] rel_q;
	logic [fbfl_pkg::FAIL_W-1:0]  fail_q;

	// item and work registers
	logic [fbfl_pkg::ACT_W-1:0]   action_q;
	logic [fbfl_pkg::CNT_W-1:0]   index_q;
	logic                         init_ok_q;
	logic [fbfl_pkg::CNT_W-1:0]   n_q;
	logic [IDX_W-1:0]             walk_q;
	logic [LINK_W-1:0]            rd_q;
	logic [fbfl_pkg::OFF_W-1:0]   prod_s1;

	logic                              m_tvalid_q;
	logic [fbfl_pkg::OUT_TDATA_W-1:0]  m_tdata_q;

	logic [LINK_W-1:0] link_mem [MAX_BLOCKS];

	logic [fbfl_pkg::ACT_W-1:0] in_action;
	logic [fbfl_pkg::CNT_W-1:0] in_index;
	logic [PW-1:0]              prod_full;
	logic [LINK_W-1:0]          rd_clamped;

	logic                         mem_we;
	logic [IDX_W-1:0]             mem_wa;
	logic [LINK_W-1:0]            mem_wd;

	logic [fbfl_pkg::STAT_W-1:0]  status_c;
	logic [fbfl_pkg::GIDX_W-1:0]  gidx_c;
	logic [fbfl_pkg::OFF_W-1:0]   off_c;
	logic [LINK_W-1:0]            head_n;
	logic                         ready_n;
	logic [fbfl_pkg::CNT_W-1:0]   pool_count_n;
	logic [fbfl_pkg::SIZE_W-1:0]  pool_size_n;
	logic [fbfl_pkg::CNT_W-1:0]   fc_n;
	logic [fbfl_pkg::TOTAL_W-1:0] alloc_n;
	logic [fbfl_pkg::TOTAL_W-1:0] rel_n;
	logic [fbfl_pkg::FAIL_W-1:0]  fail_n;
	logic                         free_we;

	assign in_action = s_tdata[1:0];
	assign in_index  = s_tdata[10:2];

	assign stat.init_go   = (in_action == fbfl_pkg::ACT_INIT) && (block_count_q != '0)
		&& (block_size_q != '0);
	assign stat.walk_last = ((32'(walk_q) + 32'd1) == 32'(n_q));
	assign stat.out_free  = !m_tvalid_q || m_tready;

	assign prod_full  = PW'(head_q[IDX_W-1:0]) * PW'(pool_size_q);
	assign rd_clamped = (rd_q > END_MARK) ? END_MARK : rd_q;

	always_comb begin
		status_c     = fbfl_pkg::ST_IGNORED;
		gidx_c       = '0;
		off_c        = '0;
		head_n       = head_q;
		ready_n      = pool_ready_q;
		pool_count_n = pool_count_q;
		pool_size_n  = pool_size_q;
		fc_n         = fc_q;
		alloc_n      = alloc_q;
		rel_n        = rel_q;
		fail_n       = fail_q;
		free_we      = 1'b0;
		case (action_q)
			fbfl_pkg::ACT_INIT: begin
				if (init_ok_q) begin
					status_c     = fbfl_pkg::ST_OK;
					head_n       = '0;
					ready_n      = 1'b1;
					pool_count_n = n_q;
					pool_size_n  = block_size_q;
					fc_n         = n_q;
				end else begin
					status_c = fbfl_pkg::ST_NOT_INIT;
				end
			end
			fbfl_pkg::ACT_ALLOC: begin
				if (!pool_ready_q) begin
					status_c = fbfl_pkg::ST_NOT_INIT;
				end else if (head_q >= END_MARK) begin
					status_c = fbfl_pkg::ST_OUT_OF_BLOCKS;
					fail_n   = fail_q + 1'b1;
				end else begin
					status_c = fbfl_pkg::ST_OK;
					gidx_c   = fbfl_pkg::GIDX_W'(head_q);
					off_c    = prod_s1;
					head_n   = rd_clamped;
					fc_n     = (fc_q != '0) ? fc_q - 1'b1 : fc_q;
					alloc_n  = alloc_q + 1'b1;
				end
			end
			fbfl_pkg::ACT_FREE: begin
				if (pool_ready_q && (index_q < pool_count_q)
					&& (32'(index_q) < MAX_BLOCKS)) begin
					status_c = fbfl_pkg::ST_OK;
					free_we  = 1'b1;
					head_n   = LINK_W'(index_q);
					fc_n     = (fc_q < pool_count_q) ? fc_q + 1'b1 : fc_q;
					rel_n    = rel_q + 1'b1;
				end
			end
			default: begin
				status_c = fbfl_pkg::ST_IGNORED;
			end
		endcase
	end

	// link table write port: init walk or a free
	assign mem_we = cmd.walk || (cmd.finish && free_we);
	assign mem_wa = cmd.walk ? walk_q : IDX_W'(index_q);
	assign mem_wd = cmd.walk ? (stat.walk_last ? END_MARK : LINK_W'(walk_q) + 1'b1) : head_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_wa] <= mem_wd;
		end
		if (cmd.accept) begin
			rd_q <= link_mem[head_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= fbfl_pkg::BLOCK_COUNT_RST;
			block_size_q  <= fbfl_pkg::BLOCK_SIZE_RST;
			head_q        <= '0;
			pool_ready_q  <= 1'b0;
			pool_count_q  <= '0;
			pool_size_q   <= '0;
			fc_q          <= '0;
			alloc_q       <= '0;
			rel_q         <= '0;
			fail_q        <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fbfl_pkg::REG_BLOCK_COUNT: block_count_q <= cfg_wdata[fbfl_pkg::CNT_W-1:0];
					fbfl_pkg::REG_BLOCK_SIZE:  block_size_q  <= cfg_wdata;
					default:                   block_size_q  <= block_size_q;
				endcase
			end
			if (cmd.finish) begin
				head_q       <= head_n;
				pool_ready_q <= ready_n;
				pool_count_q <= pool_count_n;
				pool_size_q  <= pool_size_n;
				fc_q         <= fc_n;
				alloc_q      <= alloc_n;
				rel_q        <= rel_n;
				fail_q       <= fail_n;
				m_tvalid_q   <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_q  <= in_action;
			index_q   <= in_index;
			init_ok_q <= stat.init_go;
			n_q       <= (32'(block_count_q) > MAX_BLOCKS) ? fbfl_pkg::CNT_W'(MAX_BLOCKS)
				: block_count_q;
			walk_q    <= '0;
			prod_s1   <= fbfl_pkg::OFF_W'(prod_full);
		end else if (cmd.walk) begin
			walk_q <= walk_q + 1'b1;
		end
		if (cmd.finish) begin
			m_tdata_q <= {5'b0, fail_n, rel_n, alloc_n, fc_n, off_c, gidx_c, status_c};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef NO_ASSERTIONS
	a_fc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= pool_count_q)
		else $error("free count above pool count");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= END_MARK)
		else $error("list head beyond end marker");

	a_not_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!pool_ready_q |-> (fc_q == '0) && (pool_count_q == '0))
		else $error("pool state set before init");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> stat.out_free)
		else $error("result loaded over an unread item");
`endif

endmodule

// ===== rtl/core/fixed_block_free_list_allocator_top.sv =====
// alloc, free and other items: result loaded once the output register is free; no new item until then
// init with nonzero count and size: walks n link entries, n = pool block count, one link entry per cycle
// the link table entry at the head is read on accept; the head is updated when the result is loaded
// asynchronous active-low reset clears control state, counters and the list head
// the link table is not cleared on reset; init writes every entry that is later read
module fixed_block_free_list_allocator_top #(
	parameter int MAX_BLOCKS = fbfl_pkg::DEF_MAX_BLOCKS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [fbfl_pkg::SIZE_W-1:0]      cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// action [1:0], block_index [10:2], zero [15:11]
	input  logic [fbfl_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status [1:0], granted_index [9:2], granted_offset [33:10], free_blocks [42:34],
	// alloc_total [106:43], free_total [170:107], empty_failures [202:171], zero [207:203]
	output logic [fbfl_pkg::OUT_TDATA_W-1:0] m_tdata
);

	fbfl_pkg::ctrl_cmd_t cmd;
	fbfl_pkg::dp_stat_t  stat;

	fbfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fbfl_dpath #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== tb/fixed_block_free_list_allocator_top_tb.sv =====
// testbench for the fixed block free list allocator: directed and random items against a pool model
import fbfl_pkg::*;

typedef struct {
	logic [STAT_W-1:0]  status;
	logic [GIDX_W-1:0]  gidx;
	logic [OFF_W-1:0]   goff;
	logic [CNT_W-1:0]   nfree;
	logic [TOTAL_W-1:0] allocs;
	logic [TOTAL_W-1:0] releases;
	logic [FAIL_W-1:0]  fails;
} pool_result_t;

class pool_scoreboard;
	localparam int POOL_MAX = DEF_MAX_BLOCKS;
	localparam logic [CNT_W-1:0] END_MARK = CNT_W'(POOL_MAX);

	logic [CNT_W-1:0]   reg_count;
	logic [SIZE_W-1:0]  reg_size;
	logic [CNT_W-1:0]   links [POOL_MAX];
	logic [CNT_W-1:0]   head;
	bit                 ready;
	logic [CNT_W-1:0]   nfree;
	logic [TOTAL_W-1:0] n_alloc;
	logic [TOTAL_W-1:0] n_release;
	logic [FAIL_W-1:0]  n_fail;
	logic [CNT_W-1:0]   pool_n;
	logic [SIZE_W-1:0]  pool_sz;
	logic [CNT_W-1:0]   held [$];
	pool_result_t       due_q [$];
	int                 errors;

	function new();
		reg_count = BLOCK_COUNT_RST;
		reg_size = BLOCK_SIZE_RST;
		foreach (links[i]) links[i] = '0;
		head = '0;
		ready = 0;
		nfree = '0;
		n_alloc = '0;
		n_release = '0;
		n_fail = '0;
		pool_n = '0;
		pool_sz = '0;
		errors = 0;
	endfunction

	function void set_reg(logic idx, logic [SIZE_W-1:0] val);
		if (idx == REG_BLOCK_COUNT) reg_count = val[CNT_W-1:0];
		else reg_size = val;
	endfunction

	function void note_item(logic [ACT_W-1:0] act, logic [CNT_W-1:0] idx);
		pool_result_t r;
		logic [CNT_W-1:0] n;
		logic [CNT_W-1:0] got;
		logic [31:0] prod;
		r.status = ST_OK;
		r.gidx = '0;
		r.goff = '0;
		case (act)
			ACT_INIT: begin
				if (reg_count == 0 || reg_size == 0) begin
					r.status = ST_NOT_INIT;
				end else begin
					n = (reg_count > POOL_MAX) ? CNT_W'(POOL_MAX) : reg_count;
					for (int i = 0; i < POOL_MAX; i++)
						if (i + 1 < n) links[i] = CNT_W'(i + 1);
					links[n - 1] = END_MARK;
					head = '0;
					pool_n = n;
					pool_sz = reg_size;
					nfree = n;
					ready = 1;
					held.delete();
				end
			end
			ACT_ALLOC: begin
				if (!ready) begin
					r.status = ST_NOT_INIT;
				end else if (head >= POOL_MAX) begin
					n_fail++;
					r.status = ST_OUT_OF_BLOCKS;
				end else begin
					got = head;
					head = links[got];
					if (head > END_MARK) head = END_MARK;
					if (nfree > 0) nfree--;
					n_alloc++;
					prod = 32'(got) * 32'(pool_sz);
					r.gidx = got[GIDX_W-1:0];
					r.goff = prod[OFF_W-1:0];
					held.push_back(got);
				end
			end
			ACT_FREE: begin
				if (!ready || idx >= pool_n || idx >= POOL_MAX) begin
					r.status = ST_IGNORED;
				end else begin
					links[idx] = head;
					head = idx;
					if (nfree < pool_n) nfree++;
					n_release++;
					foreach (held[k])
						if (held[k] == idx) begin
							held.delete(k);
							break;
						end
				end
			end
			default: r.status = ST_IGNORED;
		endcase
		r.nfree = nfree;
		r.allocs = n_alloc;
		r.releases = n_release;
		r.fails = n_fail;
		due_q.push_back(r);
	endfunction

	task report(string what, logic [TOTAL_W-1:0] got, logic [TOTAL_W-1:0] want);
		$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
		errors++;
	endtask

	task check_result(logic [OUT_TDATA_W-1:0] d);
		pool_result_t w;
		if (due_q.size() == 0) begin
			report("result with none due", d[63:0], '0);
			return;
		end
		w = due_q.pop_front();
		if (d[1:0] !== w.status) report("status", d[1:0], w.status);
		if (d[9:2] !== w.gidx) report("granted_index", d[9:2], w.gidx);
		if (d[33:10] !== w.goff) report("granted_offset", d[33:10], w.goff);
		if (d[42:34] !== w.nfree) report("free_blocks", d[42:34], w.nfree);
		if (d[106:43] !== w.allocs) report("alloc_total", d[106:43], w.allocs);
		if (d[170:107] !== w.releases) report("free_total", d[170:107], w.releases);
		if (d[202:171] !== w.fails) report("empty_failures", d[202:171], w.fails);
	endtask
endclass

module fixed_block_free_list_allocator_top_tb;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 300;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic                   cfg_index = 1'b0;
	logic [SIZE_W-1:0]      cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int send_idle_pct = 9;
	int recv_idle_pct = 48;
	bit hold_req = 0;
	int hold_left = 0;
	int stall_cycles = 0;

	pool_scoreboard sb = new();

	fixed_block_free_list_allocator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("fixed_block_free_list_allocator_top_tb: errors");
				$finish;
			end
		end
	end

	task automatic send_item(logic [ACT_W-1:0] act, logic [CNT_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, idx, act};
		do @(posedge clk); while (!s_tready);
		sb.note_item(act, idx);
	endtask

	// only called right after an item has gone in
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.due_q.size() > 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic set_pool(logic [SIZE_W-1:0] count_word, logic [SIZE_W-1:0] size_word);
		cfg_we <= 1'b1;
		cfg_index <= REG_BLOCK_COUNT;
		cfg_wdata <= count_word;
		@(posedge clk);
		sb.set_reg(REG_BLOCK_COUNT, count_word);
		cfg_index <= REG_BLOCK_SIZE;
		cfg_wdata <= size_word;
		@(posedge clk);
		sb.set_reg(REG_BLOCK_SIZE, size_word);
		cfg_we <= 1'b0;
	endtask

	task automatic run_segment(int n_items);
		logic [CNT_W-1:0] cnt;
		logic [SIZE_W-1:0] sz;
		logic [CNT_W-1:0] idx;
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) cnt = CNT_W'($urandom_range(1, 12));
		else if (pick < 80) cnt = CNT_W'($urandom_range(13, 255));
		else if (pick < 88) cnt = CNT_W'(256);
		else if (pick < 95) cnt = CNT_W'($urandom_range(257, 511));
		else cnt = '0;
		pick = $urandom_range(99);
		if (pick < 15) sz = 16'd1;
		else if (pick < 30) sz = 16'hFFFF;
		else if (pick < 95) sz = SIZE_W'($urandom_range(1, 65535));
		else sz = '0;
		set_pool({7'($urandom_range(127)), cnt}, sz);
		send_item(ACT_INIT, CNT_W'($urandom_range(511)));
		repeat (n_items) begin
			pick = $urandom_range(99);
			idx = CNT_W'($urandom_range(511));
			if (pick < 48) begin
				send_item(ACT_ALLOC, idx);
			end else if (pick < 80 && sb.held.size() > 0) begin
				send_item(ACT_FREE, sb.held[$urandom_range(sb.held.size() - 1)]);
			end else if (pick < 90 && sb.pool_n > 0) begin
				send_item(ACT_FREE, CNT_W'($urandom_range(sb.pool_n - 1)));
			end else if (pick < 95) begin
				send_item(ACT_FREE, idx);
			end else if (pick < 98) begin
				send_item(ACT_UNUSED, idx);
			end else begin
				send_item(ACT_INIT, idx);
			end
		end
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// before init, null and unused codes, then a full pool
		send_item(ACT_ALLOC, 9'd0);
		send_item(ACT_FREE, 9'd5);
		send_item(ACT_UNUSED, 9'd511);
		send_item(ACT_INIT, 9'd0);
		send_item(ACT_ALLOC, 9'd0);
		send_item(ACT_ALLOC, 9'd0);
		send_item(ACT_FREE, 9'd255);
		send_item(ACT_FREE, 9'd256);
		send_item(ACT_FREE, 9'd511);
		send_item(ACT_ALLOC, 9'd0);
		drain();

		// zero count rejected, then a two block pool with largest size
		set_pool(16'd0, 16'hFFFF);
		send_item(ACT_INIT, 9'd0);
		drain();
		set_pool(16'd2, 16'hFFFF);
		send_item(ACT_INIT, 9'd0);
		send_item(ACT_ALLOC, 9'd0);
		send_item(ACT_ALLOC, 9'd0);
		send_item(ACT_ALLOC, 9'd0);
		send_item(ACT_FREE, 9'd1);
		send_item(ACT_FREE, 9'd1);
		send_item(ACT_FREE, 9'd0);
		send_item(ACT_ALLOC, 9'd0);
		drain();

		// zero size rejected, oversized count saturates, single block pool
		set_pool(16'd1, 16'd0);
		send_item(ACT_INIT, 9'd0);
		drain();
		set_pool(16'hFF2C, 16'd1);
		send_item(ACT_INIT, 9'd0);
		send_item(ACT_ALLOC, 9'd0);
		drain();
		set_pool(16'd1, 16'hFFFF);
		send_item(ACT_INIT, 9'd0);
		send_item(ACT_ALLOC, 9'd0);
		send_item(ACT_ALLOC, 9'd0);
		send_item(ACT_FREE, 9'd0);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 48 : 0;
			recv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 9 : 0;
			for (int seg = 0; seg < 6; seg++) begin
				if (ph == 2 && seg == 2) hold_req = 1;
				run_segment(45);
			end
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.due_q.size() == 0) begin
			$display("fixed_block_free_list_allocator_top_tb: clean");
		end else begin
			$display("fixed_block_free_list_allocator_top_tb: errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/fbfl_pkg.sv
rtl/core/fbfl_ctrl.sv
rtl/core/fbfl_dpath.sv
rtl/core/fixed_block_free_list_allocator_top.sv
tb/fixed_block_free_list_allocator_top_tb.sv
